// ===== rtl/asc_pkg.sv =====
// shared types, widths and constants of the alignment speed controller
package asc_pkg;

  // item and register field widths
  localparam int FWD_W     = 24;
  localparam int LAT_W     = 24;
  localparam int ROT_W     = 25;
  localparam int SCALE_W   = 16;
  localparam int GAIN_W    = 24;
  localparam int THR_W     = 24;
  localparam int FLOOR_W   = 23;
  localparam int LIM_W     = 31;
  localparam int SPD_W     = 32;

  // configuration port
  localparam int CFG_NUM    = 8;
  localparam int CFG_IDX_W  = $clog2(CFG_NUM);
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_GAIN     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_ENTER  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_EXIT   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_LATERAL_FLOOR = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_FORWARD_FLOOR = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_MIN     = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_MAX     = CFG_IDX_W'(7);

  // datapath widths
  localparam int KB_W    = SCALE_W + GAIN_W;
  localparam int MUL_A_W = KB_W / 2;
  localparam int MUL_B_W = ROT_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 71;
  localparam int DIV_W   = 40;
  localparam int SHIFT_W = 6;
  localparam int KEXP_W  = 2;

  // divide by five, one byte of dividend per cycle
  localparam int DIVISOR    = 5;
  localparam int DIV_DIGITS = 8;
  localparam int DIV_STEPS  = DIV_W / DIV_DIGITS;
  localparam int REM_W      = $clog2(DIVISOR);
  localparam int DCNT_W     = $clog2(DIV_STEPS);

  localparam logic signed [LAT_W-1:0] ONE_METRE_Q = LAT_W'(65536);
  localparam logic [LAT_W-1:0]        TEN_INCH_Q  = LAT_W'(16646);

  localparam logic [DIV_W-1:0] SPD_NEG_LIM = DIV_W'(1) << (SPD_W - 1);
  localparam logic [DIV_W-1:0] SPD_POS_LIM = SPD_NEG_LIM - DIV_W'(1);

  typedef enum logic [1:0] {
    JOB_TURN = 2'd0,
    JOB_LAT  = 2'd1,
    JOB_FWD  = 2'd2
  } asc_job_e;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_PREP   = 10'b00_0000_0010,
    ST_JOB    = 10'b00_0000_0100,
    ST_MUL_LO = 10'b00_0000_1000,
    ST_MUL_HI = 10'b00_0001_0000,
    ST_SCALE  = 10'b00_0010_0000,
    ST_ROUND  = 10'b00_0100_0000,
    ST_DIV    = 10'b00_1000_0000,
    ST_STORE  = 10'b01_0000_0000,
    ST_FINISH = 10'b10_0000_0000
  } asc_state_e;

  typedef struct packed {
    logic     load;
    logic     prep;
    logic     mul_lo;
    logic     mul_hi;
    logic     scale;
    logic     round;
    logic     div;
    logic     div_first;
    logic     store;
    logic     emit;
    asc_job_e job;
  } asc_cmd_t;

  typedef struct packed {
    logic              engage;
    logic              skip;
    logic [KEXP_W-1:0] k;
    logic              out_free;
  } asc_stat_t;

endpackage

// ===== rtl/asc_if.sv =====
// word channels of the alignment speed controller
interface asc_in_if import asc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      align_active;
  logic                      target_valid;
  logic                      clear_gate;
  logic signed [FWD_W-1:0]   forward_err;
  logic signed [LAT_W-1:0]   lateral_err;
  logic signed [ROT_W-1:0]   rotation_err;
  logic        [SCALE_W-1:0] scale_factor;

  modport source (
    output valid, align_active, target_valid, clear_gate, forward_err, lateral_err,
           rotation_err, scale_factor,
    input  ready
  );
  modport sink (
    input  valid, align_active, target_valid, clear_gate, forward_err, lateral_err,
           rotation_err, scale_factor,
    output ready
  );
endinterface

interface asc_out_if import asc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    speeds_valid;
  logic signed [SPD_W-1:0] forward_speed;
  logic signed [SPD_W-1:0] left_speed;
  logic signed [SPD_W-1:0] turn_speed;
  logic                    settled;

  modport source (
    output valid, speeds_valid, forward_speed, left_speed, turn_speed, settled,
    input  ready
  );
  modport sink (
    input  valid, speeds_valid, forward_speed, left_speed, turn_speed, settled,
    output ready
  );
endinterface

// ===== rtl/asc_dp.sv =====
// datapath: config registers, settle gate, shared multiplier, divide by five, result registers
module asc_dp import asc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                      align_active_i,
  input  logic                      target_valid_i,
  input  logic                      clear_gate_i,
  input  logic signed [FWD_W-1:0]   forward_err_i,
  input  logic signed [LAT_W-1:0]   lateral_err_i,
  input  logic signed [ROT_W-1:0]   rotation_err_i,
  input  logic [SCALE_W-1:0]        scale_factor_i,
  input  asc_cmd_t                  cmd_i,
  output asc_stat_t                 stat_o,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic                      speeds_valid_o,
  output logic [SPD_W-1:0]          forward_speed_o,
  output logic [SPD_W-1:0]          left_speed_o,
  output logic [SPD_W-1:0]          turn_speed_o,
  output logic                      settled_o
);

  localparam logic [SHIFT_W-1:0] SH_TURN      = SHIFT_W'(16);
  localparam logic [SHIFT_W-1:0] SH_TURN_SLOW = SHIFT_W'(18);
  localparam logic [SHIFT_W-1:0] SH_HALF      = SHIFT_W'(29);
  localparam logic [SHIFT_W-1:0] SH_SLOW      = SHIFT_W'(30);
  localparam logic [SHIFT_W-1:0] SH_HALF_SLOW = SHIFT_W'(31);
  localparam logic [SHIFT_W-1:0] SH_SLOW_SQ   = SHIFT_W'(32);

  // configuration
  logic [GAIN_W-1:0]  turn_gain_q, move_gain_q;
  logic [THR_W-1:0]   settle_enter_q, settle_exit_q;
  logic [FLOOR_W-1:0] lateral_floor_q, forward_floor_q;
  logic [LIM_W-1:0]   speed_min_q, speed_max_q;

  // captured word
  logic               engage_q;
  logic [ROT_W-1:0]   rmag_q;
  logic [LAT_W-1:0]   latmag_q;
  logic [FWD_W-1:0]   fwdmag_q;
  logic               rot_pos_q, lat_neg_q, fwd_pos_q, big_q, slow_q;
  logic [SCALE_W-1:0] scale_q;

  logic gate_q, turn_slow_q;

  logic [KB_W-1:0]    kbase_q;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [DIV_W-1:0]   dv_q, dv_d;
  logic [REM_W-1:0]   rem_q, rem_d;
  logic [SPD_W-1:0]   turn_spd_q, fwd_spd_q, left_spd_q;

  logic               out_valid_q, out_sv_q, out_settled_q;
  logic [SPD_W-1:0]   out_fwd_q, out_left_q, out_turn_q;

  // input magnitudes and flags
  logic [ROT_W-1:0] rot_u, rmag_d;
  logic [LAT_W-1:0] lat_u, latmag_d;
  logic [FWD_W-1:0] fwd_u, fwdmag_d;

  assign rot_u    = rotation_err_i;
  assign lat_u    = lateral_err_i;
  assign fwd_u    = forward_err_i;
  assign rmag_d   = rot_u[ROT_W-1] ? ('0 - rot_u) : rot_u;
  assign latmag_d = lat_u[LAT_W-1] ? ('0 - lat_u) : lat_u;
  assign fwdmag_d = fwd_u[FWD_W-1] ? ('0 - fwd_u) : fwd_u;

  // per-job operands
  logic [KB_W-1:0]    k_op;
  logic [MUL_B_W-1:0] m_op;
  logic [KEXP_W-1:0]  k_sel;
  logic [SHIFT_W-1:0] shamt;
  logic               skip;

  always_comb begin
    k_op  = KB_W'(turn_gain_q);
    m_op  = rmag_q;
    k_sel = turn_slow_q ? KEXP_W'(1) : KEXP_W'(0);
    shamt = turn_slow_q ? SH_TURN_SLOW : SH_TURN;
    skip  = 1'b0;
    case (cmd_i.job)
      JOB_TURN: begin
        skip = 1'b0;
      end
      JOB_LAT: begin
        k_op  = kbase_q;
        m_op  = MUL_B_W'(latmag_q);
        k_sel = big_q ? KEXP_W'(0) : KEXP_W'(1);
        shamt = big_q ? SH_HALF : SH_SLOW;
        skip  = !gate_q || (latmag_q <= LAT_W'(lateral_floor_q));
      end
      JOB_FWD: begin
        k_op = kbase_q;
        m_op = MUL_B_W'(fwdmag_q);
        if (big_q) begin
          k_sel = slow_q ? KEXP_W'(1) : KEXP_W'(0);
          shamt = slow_q ? SH_HALF_SLOW : SH_HALF;
        end else begin
          k_sel = slow_q ? KEXP_W'(2) : KEXP_W'(1);
          shamt = slow_q ? SH_SLOW_SQ : SH_SLOW;
        end
        skip = !gate_q || (fwdmag_q <= FWD_W'(forward_floor_q));
      end
      default: begin
        skip = 1'b0;
      end
    endcase
  end

  // shared multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;

  always_comb begin
    if (cmd_i.prep) begin
      mul_a = MUL_A_W'(scale_q);
      mul_b = MUL_B_W'(move_gain_q);
    end else if (cmd_i.mul_hi) begin
      mul_a = k_op[KB_W-1:MUL_A_W];
      mul_b = m_op;
    end else begin
      mul_a = k_op[MUL_A_W-1:0];
      mul_b = m_op;
    end
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // rounding term 5^k * 2^(s-1)
  logic [ACC_W-1:0] rnd, rsum, rshift;
  logic [4:0]       rnd_mul;

  always_comb begin
    case (k_sel)
      KEXP_W'(1): rnd_mul = 5'd5;
      KEXP_W'(2): rnd_mul = 5'd25;
      default:    rnd_mul = 5'd1;
    endcase
  end

  assign rnd    = ACC_W'(rnd_mul) << (shamt - SHIFT_W'(1));
  assign rsum   = acc_q + rnd;
  assign rshift = rsum >> shamt;

  // one byte of long division by five
  logic [REM_W:0]        dvt;
  logic [REM_W-1:0]      dvr;
  logic [DIV_DIGITS-1:0] dvq;

  always_comb begin
    dvr = cmd_i.div_first ? '0 : rem_q;
    dvq = '0;
    dvt = '0;
    for (int i = 0; i < DIV_DIGITS; i++) begin
      dvt = {dvr, dv_q[DIV_W-1-i]};
      if (dvt >= (REM_W+1)'(DIVISOR)) begin
        dvq[DIV_DIGITS-1-i] = 1'b1;
        dvt = dvt - (REM_W+1)'(DIVISOR);
      end
      dvr = dvt[REM_W-1:0];
    end
  end

  always_comb begin
    acc_d = acc_q;
    dv_d  = dv_q;
    rem_d = rem_q;
    if (cmd_i.mul_lo) begin
      acc_d = ACC_W'(prod);
    end else if (cmd_i.mul_hi) begin
      acc_d = acc_q + ACC_W'({prod, {MUL_A_W{1'b0}}});
    end else if (cmd_i.scale) begin
      acc_d = (acc_q << 3) + (acc_q << 2) + acc_q;
    end
    if (cmd_i.round) begin
      dv_d = rshift[DIV_W-1:0];
    end else if (cmd_i.div) begin
      dv_d  = {dv_q[DIV_W-DIV_DIGITS-1:0], dvq};
      rem_d = dvr;
    end
  end

  // clamp a translation magnitude to [min, max] and apply the sign
  function automatic logic [SPD_W-1:0] clamp_spd(input logic [DIV_W-1:0] m,
                                                 input logic neg,
                                                 input logic [LIM_W-1:0] lo,
                                                 input logic [LIM_W-1:0] hi);
    logic [LIM_W-1:0] mag;
    if (m < DIV_W'(lo)) begin
      mag = lo;
    end else if (m > DIV_W'(hi)) begin
      mag = hi;
    end else begin
      mag = m[LIM_W-1:0];
    end
    return neg ? ('0 - SPD_W'(mag)) : SPD_W'(mag);
  endfunction

  logic [DIV_W-1:0] turn_mag;
  logic [SPD_W-1:0] turn_val;
  logic             kb_nz;

  assign kb_nz = (kbase_q != '0);

  always_comb begin
    if (rot_pos_q) begin
      turn_mag = (dv_q > SPD_NEG_LIM) ? SPD_NEG_LIM : dv_q;
      turn_val = '0 - turn_mag[SPD_W-1:0];
    end else begin
      turn_mag = (dv_q > SPD_POS_LIM) ? SPD_POS_LIM : dv_q;
      turn_val = turn_mag[SPD_W-1:0];
    end
  end

  // settle gate update with hysteresis
  logic gate_upd;

  always_comb begin
    gate_upd = gate_q;
    if (rmag_q < ROT_W'(settle_enter_q)) begin
      gate_upd = 1'b1;
    end
    if (gate_upd && (rmag_q > ROT_W'(settle_exit_q))) begin
      gate_upd = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_gain_q     <= '0;
      move_gain_q     <= '0;
      settle_enter_q  <= '0;
      settle_exit_q   <= '0;
      lateral_floor_q <= '0;
      forward_floor_q <= '0;
      speed_min_q     <= '0;
      speed_max_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TURN_GAIN:     turn_gain_q     <= cfg_wdata_i[GAIN_W-1:0];
        REG_MOVE_GAIN:     move_gain_q     <= cfg_wdata_i[GAIN_W-1:0];
        REG_SETTLE_ENTER:  settle_enter_q  <= cfg_wdata_i[THR_W-1:0];
        REG_SETTLE_EXIT:   settle_exit_q   <= cfg_wdata_i[THR_W-1:0];
        REG_LATERAL_FLOOR: lateral_floor_q <= cfg_wdata_i[FLOOR_W-1:0];
        REG_FORWARD_FLOOR: forward_floor_q <= cfg_wdata_i[FLOOR_W-1:0];
        REG_SPEED_MIN:     speed_min_q     <= cfg_wdata_i[LIM_W-1:0];
        REG_SPEED_MAX:     speed_max_q     <= cfg_wdata_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q      <= 1'b0;
      turn_slow_q <= 1'b0;
    end else if (cmd_i.load) begin
      gate_q <= gate_q & ~clear_gate_i;
    end else if (cmd_i.prep) begin
      turn_slow_q <= gate_q;
      gate_q      <= gate_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      engage_q   <= align_active_i & target_valid_i;
      rmag_q     <= rmag_d;
      latmag_q   <= latmag_d;
      fwdmag_q   <= fwdmag_d;
      rot_pos_q  <= !rot_u[ROT_W-1] && (rot_u != '0);
      lat_neg_q  <= lat_u[LAT_W-1];
      fwd_pos_q  <= !fwd_u[FWD_W-1] && (fwd_u != '0);
      big_q      <= (lateral_err_i > ONE_METRE_Q) || (forward_err_i > ONE_METRE_Q);
      slow_q     <= latmag_d > TEN_INCH_Q;
      scale_q    <= scale_factor_i;
      turn_spd_q <= '0;
      fwd_spd_q  <= '0;
      left_spd_q <= '0;
    end else if (cmd_i.store) begin
      case (cmd_i.job)
        JOB_TURN: turn_spd_q <= turn_val;
        JOB_LAT:  fwd_spd_q  <= clamp_spd(dv_q, lat_neg_q && kb_nz, speed_min_q, speed_max_q);
        JOB_FWD:  left_spd_q <= clamp_spd(dv_q, fwd_pos_q && kb_nz, speed_min_q, speed_max_q);
        default: ;
      endcase
    end
    if (cmd_i.prep) begin
      kbase_q <= prod[KB_W-1:0];
    end
    acc_q <= acc_d;
    dv_q  <= dv_d;
    rem_q <= rem_d;
    if (cmd_i.emit) begin
      out_sv_q      <= engage_q;
      out_fwd_q     <= fwd_spd_q;
      out_left_q    <= left_spd_q;
      out_turn_q    <= turn_spd_q;
      out_settled_q <= gate_q;
    end
  end

  assign stat_o.engage   = engage_q;
  assign stat_o.skip     = skip;
  assign stat_o.k        = k_sel;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign speeds_valid_o  = out_sv_q;
  assign forward_speed_o = out_fwd_q;
  assign left_speed_o    = out_left_q;
  assign turn_speed_o    = out_turn_q;
  assign settled_o       = out_settled_q;

endmodule

// ===== rtl/asc_ctrl.sv =====
// controller: sequences the turn, lateral and forward jobs through the shared datapath
module asc_ctrl import asc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  asc_stat_t stat_i,
  output asc_cmd_t  cmd_o
);

  asc_state_e        state_q, state_d;
  asc_job_e          job_q, job_d;
  logic [DCNT_W-1:0] ctr_q, ctr_d;
  logic [KEXP_W-1:0] pass_q, pass_d;

  function automatic asc_job_e next_job(input asc_job_e j);
    case (j)
      JOB_TURN: return JOB_LAT;
      JOB_LAT:  return JOB_FWD;
      default:  return JOB_FWD;
    endcase
  endfunction

  always_comb begin
    state_d    = state_q;
    job_d      = job_q;
    ctr_d      = ctr_q;
    pass_d     = pass_q;
    cmd_o      = '0;
    cmd_o.job  = job_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        if (stat_i.engage) begin
          cmd_o.prep = 1'b1;
          job_d      = JOB_TURN;
          state_d    = ST_JOB;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_JOB: begin
        if (!stat_i.skip) begin
          state_d = ST_MUL_LO;
        end else if (job_q == JOB_FWD) begin
          state_d = ST_FINISH;
        end else begin
          job_d = next_job(job_q);
        end
      end
      ST_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        pass_d       = '0;
        state_d      = (stat_i.k == '0) ? ST_ROUND : ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        if ((pass_q + KEXP_W'(1)) == stat_i.k) begin
          pass_d  = '0;
          state_d = ST_ROUND;
        end else begin
          pass_d = pass_q + KEXP_W'(1);
        end
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        ctr_d       = '0;
        pass_d      = '0;
        state_d     = (stat_i.k == '0) ? ST_STORE : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div       = 1'b1;
        cmd_o.div_first = (ctr_q == '0);
        if (ctr_q == DCNT_W'(DIV_STEPS - 1)) begin
          ctr_d = '0;
          if ((pass_q + KEXP_W'(1)) == stat_i.k) begin
            state_d = ST_STORE;
          end else begin
            pass_d = pass_q + KEXP_W'(1);
          end
        end else begin
          ctr_d = ctr_q + DCNT_W'(1);
        end
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        if (job_q == JOB_FWD) begin
          state_d = ST_FINISH;
        end else begin
          job_d   = next_job(job_q);
          state_d = ST_JOB;
        end
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      job_q   <= JOB_TURN;
      ctr_q   <= '0;
      pass_q  <= '0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      ctr_q   <= ctr_d;
      pass_q  <= pass_d;
    end
  end

endmodule

// ===== rtl/alignment_speed_controller.sv =====
// top level of the alignment speed controller
// one word at a time: the next word is taken only after the result of the last is registered,
// and a stalled output register holds that result back
// the long path is the divide-by-five unit (up to 2 passes per speed)
// behind one shared 20x25 multiplier; a finished result waits in an output register
// reset: all gains, thresholds and limits read zero, settle gate clear, no result pending
module alignment_speed_controller import asc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  asc_in_if.sink                in_if,
  asc_out_if.source             out_if
);

  asc_cmd_t  cmd;
  asc_stat_t stat;
  logic      in_ready;

  asc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  asc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .align_active_i  (in_if.align_active),
    .target_valid_i  (in_if.target_valid),
    .clear_gate_i    (in_if.clear_gate),
    .forward_err_i   (in_if.forward_err),
    .lateral_err_i   (in_if.lateral_err),
    .rotation_err_i  (in_if.rotation_err),
    .scale_factor_i  (in_if.scale_factor),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_ready_i     (out_if.ready),
    .out_valid_o     (out_if.valid),
    .speeds_valid_o  (out_if.speeds_valid),
    .forward_speed_o (out_if.forward_speed),
    .left_speed_o    (out_if.left_speed),
    .turn_speed_o    (out_if.turn_speed),
    .settled_o       (out_if.settled)
  );

  assign in_if.ready = in_ready;

  // one word in flight: the cycle after acceptance takes nothing
  a_single_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("word accepted while another is in progress");

  // no command means all speeds zero
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.speeds_valid |->
      out_if.forward_speed == '0 && out_if.left_speed == '0 && out_if.turn_speed == '0)
    else $error("speeds nonzero without a command");

  // translation only while the settle gate is set
  a_gate_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.settled |->
      out_if.forward_speed == '0 && out_if.left_speed == '0)
    else $error("translation speed while rotation not settled");

endmodule
